// File: hdl/bqeq_pkg.sv
// ----------------------------------------------------------------------------
// bqeq_pkg
// Shared types and constants of the cascaded biquad equaliser.
// ----------------------------------------------------------------------------
`default_nettype none

package bqeq_pkg;

  // Fixed-point constants
  localparam int                 COEFS_PER_SECTION = 5;
  localparam logic signed [31:0] COEF_ONE          = 32'sh1000_0000;  // 1.0 in Q4.28
  localparam logic [23:0]        GAIN_UNITY        = 24'd2097152;     // 1.0 in Q3.21
  localparam logic [24:0]        GAIN_SETTLE_LSB   = 25'd2;
  localparam logic [23:0]        ALPHA_RESET       = 24'd10918;

  // Input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Coefficient slots within a section
  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  // MAC sequencing: last step of the five-product pipeline
  localparam logic [2:0] MAC_LAST_STEP = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_SECTIONS = 2'd0;
  localparam logic [1:0] CFG_IDX_ALPHA    = 2'd1;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_GAIN_MUL,
    S_GAIN_UPD,
    S_RD_X1,
    S_RD_X2,
    S_X_FIN,
    S_RD_Y1,
    S_RD_Y2,
    S_CAP_Y2,
    S_MAC,
    S_SEC_WB,
    S_APP_MUL,
    S_OUT
  } state_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_COEF_WR,
    OP_GAIN_MUL,
    OP_GAIN_UPD,
    OP_RD_X1,
    OP_RD_X2,
    OP_X_FIN,
    OP_RD_Y1,
    OP_RD_Y2,
    OP_CAP_Y2,
    OP_MAC,
    OP_SEC_WB,
    OP_APP_MUL,
    OP_OUT
  } dp_op_e;

  // Controller to datapath command
  typedef struct packed {
    dp_op_e     op;
    logic [2:0] mac_step;
    logic       sec_active;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       is_coef;
    logic       new_frame;
    logic       ch_ok;
    logic       out_free;
    logic [3:0] active_sections;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/bqeq_ctrl.sv
// ----------------------------------------------------------------------------
// bqeq_ctrl
// Sequencer of the equaliser: writes coefficients; walks each sample through
// gain step (new frame only), delay fetch, per-section MAC and gain application.
// ----------------------------------------------------------------------------
`default_nettype none

module bqeq_ctrl #(
  parameter  int MAX_SECTIONS = 8,
  localparam int SecW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire bqeq_pkg::dp_status_t status_i,
  output bqeq_pkg::dp_cmd_t         cmd_o,
  output logic [SecW-1:0]           sec_o
);
  import bqeq_pkg::*;

  state_e          state_q, state_d;
  logic [SecW-1:0] sec_q, sec_d;
  logic [2:0]      step_q, step_d;
  logic            sec_active;
  logic            sec_last;

  assign sec_active = int'(sec_q) < int'(status_i.active_sections);
  assign sec_last   = int'(sec_q) == (MAX_SECTIONS - 1);
  assign sec_o      = sec_q;

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sec_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
      step_q  <= step_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d            = state_q;
    sec_d              = sec_q;
    step_d             = step_q;
    in_ready_o         = 1'b0;
    cmd_o.op           = OP_NOP;
    cmd_o.mac_step     = step_q;
    cmd_o.sec_active   = sec_active;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        sec_d  = '0;
        step_d = '0;
        if (status_i.is_coef) begin
          cmd_o.op = OP_COEF_WR;
          state_d  = S_IDLE;
        end else if (status_i.new_frame) begin
          state_d = S_GAIN_MUL;
        end else if (status_i.ch_ok) begin
          state_d = S_RD_X1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_GAIN_MUL: begin
        cmd_o.op = OP_GAIN_MUL;
        state_d  = S_GAIN_UPD;
      end
      S_GAIN_UPD: begin
        cmd_o.op = OP_GAIN_UPD;
        state_d  = status_i.ch_ok ? S_RD_X1 : S_IDLE;
      end
      S_RD_X1: begin
        cmd_o.op = OP_RD_X1;
        state_d  = S_RD_X2;
      end
      S_RD_X2: begin
        cmd_o.op = OP_RD_X2;
        state_d  = S_X_FIN;
      end
      S_X_FIN: begin
        cmd_o.op = OP_X_FIN;
        state_d  = S_RD_Y1;
      end
      S_RD_Y1: begin
        cmd_o.op = OP_RD_Y1;
        state_d  = S_RD_Y2;
      end
      S_RD_Y2: begin
        cmd_o.op = OP_RD_Y2;
        state_d  = S_CAP_Y2;
      end
      S_CAP_Y2: begin
        cmd_o.op = OP_CAP_Y2;
        step_d   = '0;
        state_d  = sec_active ? S_MAC : S_SEC_WB;
      end
      S_MAC: begin
        cmd_o.op = OP_MAC;
        if (step_q == MAC_LAST_STEP) begin
          step_d  = '0;
          state_d = S_SEC_WB;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_SEC_WB: begin
        cmd_o.op = OP_SEC_WB;
        if (sec_last) begin
          sec_d   = '0;
          state_d = S_APP_MUL;
        end else begin
          sec_d   = sec_q + SecW'(1);
          state_d = S_RD_Y1;
        end
      end
      S_APP_MUL: begin
        cmd_o.op = OP_APP_MUL;
        state_d  = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/bqeq_dpath.sv
// ----------------------------------------------------------------------------
// bqeq_dpath
// Datapath: coefficient and delay memories, shared 33x33 multiplier,
// accumulator, gain smoother, configuration and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bqeq_dpath #(
  parameter  int MAX_SECTIONS = 8,
  parameter  int MAX_CHANNELS = 8,
  localparam int SecW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bqeq_pkg::dp_cmd_t  cmd_i,
  input  wire logic [SecW-1:0]    sec_i,
  output bqeq_pkg::dp_status_t    status_o,
  // input item
  input  wire logic               cmd_in_i,
  input  wire logic [2:0]         channel_i,
  input  wire logic signed [23:0] sample_in_i,
  input  wire logic               new_frame_i,
  input  wire logic [23:0]        gain_target_i,
  input  wire logic [2:0]         coef_section_i,
  input  wire logic [2:0]         coef_slot_i,
  input  wire logic signed [31:0] coef_value_i,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i,
  // result
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic signed [23:0]      sample_out_o,
  output logic [2:0]              channel_out_o
);
  import bqeq_pkg::*;

  localparam int DPC    = 2 * MAX_SECTIONS + 2;
  localparam int DDEPTH = MAX_CHANNELS * DPC;
  localparam int DAW    = $clog2(DDEPTH);
  localparam int CDEPTH = MAX_SECTIONS * COEFS_PER_SECTION;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

  // Saturating narrowing helpers
  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -67'sh0_8000_0000) r = 32'sh8000_0000;
    else                            r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [36:0] v);
    logic signed [23:0] r;
    if (v > 37'sh7F_FFFF)       r = 24'sh7F_FFFF;
    else if (v < -37'sh80_0000) r = 24'sh80_0000;
    else                        r = v[23:0];
    return r;
  endfunction

  // Configuration registers
  logic [3:0]  active_q;
  logic [23:0] alpha_q;

  // Latched transaction
  logic               cmd_q;
  logic [2:0]         ch_q;
  logic               nf_q;
  logic [23:0]        target_q;
  logic [2:0]         csec_q;
  logic [2:0]         cslot_q;
  logic signed [31:0] cval_q;

  // Working registers
  logic signed [31:0] cur_q, in1_q, in2_q, y1_q, y2_q;
  logic signed [65:0] prod_q;
  logic signed [66:0] acc_q;
  logic [23:0]        gain_q;
  logic               bypass_q;

  // Memories
  logic signed [31:0] dmem [DDEPTH];
  logic [DDEPTH-1:0]  dvalid_q;
  logic signed [31:0] dly_rdata_q;
  logic signed [31:0] cmem [CDEPTH];
  logic [CDEPTH-1:0]  cvalid_q;
  logic signed [31:0] coef_rdata_q;

  // Output register
  logic               out_valid_q;
  logic signed [23:0] sample_out_q;
  logic [2:0]         channel_out_q;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.is_coef         = (cmd_q == CMD_COEF);
  assign status_o.new_frame       = nf_q;
  assign status_o.ch_ok           = int'(ch_q) < MAX_CHANNELS;
  assign status_o.out_free        = out_free;
  assign status_o.active_sections = active_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 4'd0;
      alpha_q  <= ALPHA_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IDX_SECTIONS: active_q <= cfg_data_i[3:0];
        CFG_IDX_ALPHA:    alpha_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Delay memory port control
  logic            d_re, d_we;
  logic [DAW-1:0]  d_raddr, d_waddr;
  logic signed [31:0] d_wdata;
  logic signed [31:0] yo;
  int              dbase, sidx;

  always_comb begin
    dbase   = int'(ch_q) * DPC;
    sidx    = 2 * int'(sec_i) + 2;
    d_re    = 1'b0;
    d_we    = 1'b0;
    d_raddr = DAW'(dbase);
    d_waddr = DAW'(dbase);
    d_wdata = cur_q;
    unique case (cmd_i.op)
      OP_RD_X1: begin
        d_re = 1'b1;
      end
      OP_RD_X2: begin
        d_re    = 1'b1;
        d_raddr = DAW'(dbase + 1);
        d_we    = 1'b1;
        d_wdata = cur_q;
      end
      OP_X_FIN: begin
        d_we    = 1'b1;
        d_waddr = DAW'(dbase + 1);
        d_wdata = in1_q;
      end
      OP_RD_Y1: begin
        d_re    = 1'b1;
        d_raddr = DAW'(dbase + sidx);
      end
      OP_RD_Y2: begin
        // fetch y2 and shift y1 into its place in the same cycle
        d_re    = 1'b1;
        d_raddr = DAW'(dbase + sidx + 1);
        d_we    = 1'b1;
        d_waddr = DAW'(dbase + sidx + 1);
        d_wdata = dly_rdata_q;
      end
      OP_SEC_WB: begin
        d_we    = 1'b1;
        d_waddr = DAW'(dbase + sidx);
        d_wdata = yo;
      end
      default: ;
    endcase
  end

  // Delay memory, read before write; never-written entries read as zero
  always_ff @(posedge clk_i) begin
    if (d_we) dmem[d_waddr] <= d_wdata;
    if (d_re) dly_rdata_q <= dvalid_q[d_raddr] ? dmem[d_raddr] : 32'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)   dvalid_q <= '0;
    else if (d_we) dvalid_q[d_waddr] <= 1'b1;
  end

  // Coefficient memory port control
  logic           c_we, c_re;
  logic [CAW-1:0] c_waddr, c_raddr;

  assign c_we    = (cmd_i.op == OP_COEF_WR) && (int'(csec_q) < MAX_SECTIONS) &&
                   (cslot_q <= SLOT_A2);
  assign c_waddr = CAW'(int'(csec_q) * COEFS_PER_SECTION + int'(cslot_q));
  assign c_re    = (cmd_i.op == OP_MAC) && (cmd_i.mac_step <= SLOT_A2);
  assign c_raddr = CAW'(int'(sec_i) * COEFS_PER_SECTION + int'(cmd_i.mac_step));

  // Unwritten entries hold the identity section
  always_ff @(posedge clk_i) begin
    if (c_we) cmem[c_waddr] <= cval_q;
    if (c_re) begin
      if (cvalid_q[c_raddr])              coef_rdata_q <= cmem[c_raddr];
      else if (cmd_i.mac_step == SLOT_B0) coef_rdata_q <= COEF_ONE;
      else                                coef_rdata_q <= 32'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)   cvalid_q <= '0;
    else if (c_we) cvalid_q[c_waddr] <= 1'b1;
  end

  // Gain error and settle test
  logic signed [24:0] gdiff, gabs;
  logic               settle;
  assign gdiff  = $signed({1'b0, target_q}) - $signed({1'b0, gain_q});
  assign gabs   = gdiff[24] ? -gdiff : gdiff;
  assign settle = ($unsigned(gabs) <= GAIN_SETTLE_LSB) && (target_q == GAIN_UNITY);

  // Shared multiplier operand selection
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] mac_opnd;
  logic signed [65:0] mul_p;

  always_comb begin
    unique case (cmd_i.mac_step)
      3'd1:    mac_opnd = cur_q;
      3'd2:    mac_opnd = in1_q;
      3'd3:    mac_opnd = in2_q;
      3'd4:    mac_opnd = y1_q;
      3'd5:    mac_opnd = y2_q;
      default: mac_opnd = 32'sd0;
    endcase
    unique case (cmd_i.op)
      OP_GAIN_MUL: begin
        mul_a = $signed({9'd0, alpha_q});
        mul_b = 33'(gdiff);
      end
      OP_APP_MUL: begin
        mul_a = 33'(cur_q);
        mul_b = $signed({9'd0, gain_q});
      end
      default: begin
        mul_a = 33'(coef_rdata_q);
        mul_b = 33'(mac_opnd);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Section result: round at Q.28, saturate; identity when inactive
  logic signed [66:0] acc_rnd, acc_sh;
  assign acc_rnd = acc_q + 67'sh800_0000;
  assign acc_sh  = acc_rnd >>> 28;
  assign yo      = cmd_i.sec_active ? sat32(acc_sh) : cur_q;

  // Gain update: gain += round(alpha * diff / 2^24), clamp to 24 bits
  logic signed [49:0] g_rnd;
  logic signed [25:0] g_step;
  logic signed [26:0] g_new;
  assign g_rnd  = prod_q[49:0] + 50'sh80_0000;
  assign g_step = g_rnd[49:24];
  assign g_new  = $signed({3'd0, gain_q}) + 27'(g_step);

  // Gain application: round(y * gain / 2^21)
  logic signed [57:0] a_rnd;
  logic signed [36:0] a_sh;
  logic signed [23:0] out_val;
  assign a_rnd   = prod_q[57:0] + 58'sh10_0000;
  assign a_sh    = a_rnd[57:21];
  assign out_val = bypass_q ? sat24(37'(cur_q)) : sat24(a_sh);

  // Gain smoother state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_UNITY;
      bypass_q <= 1'b1;
    end else if (cmd_i.op == OP_GAIN_MUL) begin
      bypass_q <= settle;
    end else if (cmd_i.op == OP_GAIN_UPD && !bypass_q) begin
      if (g_new < 27'sd0)                     gain_q <= 24'd0;
      else if (g_new > 27'sh0FF_FFFF)         gain_q <= 24'hFF_FFFF;
      else                                    gain_q <= g_new[23:0];
    end
  end

  // Transaction latch and arithmetic registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        cmd_q    <= cmd_in_i;
        ch_q     <= channel_i;
        nf_q     <= new_frame_i;
        target_q <= gain_target_i;
        csec_q   <= coef_section_i;
        cslot_q  <= coef_slot_i;
        cval_q   <= coef_value_i;
        cur_q    <= 32'(sample_in_i);
      end
      OP_GAIN_MUL: prod_q <= mul_p;
      OP_APP_MUL:  prod_q <= mul_p;
      OP_RD_X2:    in1_q  <= dly_rdata_q;
      OP_X_FIN:    in2_q  <= dly_rdata_q;
      OP_RD_Y2:    y1_q   <= dly_rdata_q;
      OP_CAP_Y2: begin
        y2_q  <= dly_rdata_q;
        acc_q <= '0;
      end
      OP_MAC: begin
        // coef fetch at step k, product at k+1, accumulate at k+2
        if (cmd_i.mac_step >= 3'd1 && cmd_i.mac_step <= 3'd5) prod_q <= mul_p;
        if (cmd_i.mac_step >= 3'd2) begin
          if (cmd_i.mac_step - 3'd2 < SLOT_A1) acc_q <= acc_q + 67'(prod_q);
          else                                 acc_q <= acc_q - 67'(prod_q);
        end
      end
      OP_SEC_WB: begin
        cur_q <= yo;
        in1_q <= y1_q;
        in2_q <= y2_q;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_OUT) begin
      sample_out_q  <= out_val;
      channel_out_q <= ch_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = sample_out_q;
  assign channel_out_o = channel_out_q;

endmodule

`default_nettype wire

// File: hdl/biquad_cascade_eq_with_gain_ramp.sv
// A sample runs through the gain step (on new_frame), delay fetch, a pass
//   for each of the MAX_SECTIONS sections (MAC only on active ones) and
//   gain application; no new input is taken before its result is in the
//   output register. One delay memory and one multiplier walk all sections.
// Coefficients are written in decode. Reset is asynchronous: coefficients read
//   as identity, delays as zero and gain as unity until written; no clear pass.
// ----------------------------------------------------------------------------
// biquad_cascade_eq_with_gain_ramp
// Multichannel direct-form-I biquad cascade with a smoothed master gain.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_cascade_eq_with_gain_ramp #(
  parameter int MAX_SECTIONS = 8,
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               cmd_i,
  input  wire logic [2:0]         channel_i,
  input  wire logic signed [23:0] sample_in_i,
  input  wire logic               new_frame_i,
  input  wire logic [23:0]        gain_target_i,
  input  wire logic [2:0]         coef_section_i,
  input  wire logic [2:0]         coef_slot_i,
  input  wire logic signed [31:0] coef_value_i,
  // configuration channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [23:0]      sample_out_o,
  output logic [2:0]              channel_out_o
);
  import bqeq_pkg::*;

  localparam int SecW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  dp_cmd_t         dp_cmd;
  dp_status_t      dp_status;
  logic [SecW-1:0] sec;

  assign cfg_ready_o = 1'b1;

  bqeq_ctrl #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd),
    .sec_o      (sec)
  );

  bqeq_dpath #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .sec_i          (sec),
    .status_o       (dp_status),
    .cmd_in_i       (cmd_i),
    .channel_i      (channel_i),
    .sample_in_i    (sample_in_i),
    .new_frame_i    (new_frame_i),
    .gain_target_i  (gain_target_i),
    .coef_section_i (coef_section_i),
    .coef_slot_i    (coef_slot_i),
    .coef_value_i   (coef_value_i),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .sample_out_o   (sample_out_o),
    .channel_out_o  (channel_out_o)
  );

endmodule

`default_nettype wire

// File: hdl/bqeq_checker.sv
// ----------------------------------------------------------------------------
// bqeq_checker
// Port-level checks of the equaliser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bqeq_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic signed [23:0] sample_out_o,
  input wire logic [2:0]        channel_out_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o) &&
                                    $stable(channel_out_o))
    else $error("result changed while stalled");

  // One transaction in flight: input closes after an accepted transaction
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // No result appears in the cycle after an acceptance
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result without processing time");

  // A new result only comes from a transaction being worked on
  a_rose_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised while idle");

endmodule

bind biquad_cascade_eq_with_gain_ramp bqeq_checker u_bqeq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .sample_out_o  (sample_out_o),
  .channel_out_o (channel_out_o)
);

`default_nettype wire
